[design/lznt1_stream_decompressor_assert.svh]
//------------------------------------------------------------------------------
// Assertion macros for the decompressor
// Clocked on clk, disabled while rst_n is low.
//------------------------------------------------------------------------------
`ifndef LZNT1_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZNT1_STREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication
`define LZNT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LZNT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lznt_pkg.sv]
//------------------------------------------------------------------------------
// lznt_pkg
// Shared constants and transfer types for the decompressor.
//------------------------------------------------------------------------------
package lznt_pkg;

    localparam int CHUNK_BYTES = 4096;
    localparam int HIST_AW     = 12;

    localparam logic OP_SUPPLY = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SIG   = 3'd1;
    localparam logic [2:0] ST_EARLY = 3'd2;
    localparam logic [2:0] ST_REF   = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;
    localparam logic [2:0] ST_BUSY  = 3'd5;

    // Request from the parser to the history stage
    typedef struct packed {
        logic               emit;
        logic               copy;    // byte comes from history read
        logic               wr;      // byte goes into history
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
        logic               last;
        logic [2:0]         status;
    } req_t;

    // Result leaving the history stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } res_t;

endpackage

[design/lznt_parser.sv]
//------------------------------------------------------------------------------
// lznt_parser
// Chunk header, flag and token parser; issues history reads and writes.
//------------------------------------------------------------------------------
module lznt_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          op,
    input  logic [7:0]                    in_byte,
    input  logic                          last_in,
    input  logic [20:0]                   output_size,
    output lznt_pkg::req_t                req,
    output logic [lznt_pkg::HIST_AW-1:0]  rd_addr
);

    typedef enum logic [2:0]
    {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_STORED,
        PH_FLAG,
        PH_ITEM,
        PH_TOKEN_HI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [12:0] pos_reg, pos_next;
    logic [12:0] left_reg, left_next;
    logic [20:0] produced_reg, produced_next;
    logic [7:0]  flags_reg, flags_next;
    logic [2:0]  slot_reg, slot_next;
    logic [7:0]  held_reg, held_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] dist_reg, dist_next;
    logic        zf_reg, zf_next;
    logic        fin_reg, fin_next;
    logic        ended_reg, ended_next;

    logic        do_emit, do_err, do_adv;
    logic [7:0]  emit_data;
    logic [2:0]  err_code;
    logic [15:0] hword;
    logic [11:0] u;
    logic [3:0]  k;
    logic [11:0] len_mask;
    logic [12:0] tok_len, tok_dist;
    logic [13:0] tok_end;
    logic [21:0] count_inc;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        produced_next = produced_reg;
        flags_next    = flags_reg;
        slot_next     = slot_reg;
        held_next     = held_reg;
        rem_next      = rem_reg;
        dist_next     = dist_reg;
        zf_next       = zf_reg;
        fin_next      = fin_reg;
        ended_next    = ended_reg;
        do_emit       = 1'b0;
        do_err        = 1'b0;
        do_adv        = 1'b0;
        emit_data     = 8'd0;
        err_code      = lznt_pkg::ST_OK;
        req           = '0;
        rd_addr       = pos_reg[11:0] - dist_reg[11:0];
        hword         = {in_byte, held_reg};

        // Offset/length split follows the chunk position
        u = pos_reg[11:0] - 12'd1;
        priority if (u[11])      k = 4'd8;
        else if (u[10])          k = 4'd7;
        else if (u[9])           k = 4'd6;
        else if (u[8])           k = 4'd5;
        else if (u[7])           k = 4'd4;
        else if (u[6])           k = 4'd3;
        else if (u[5])           k = 4'd2;
        else if (u[4])           k = 4'd1;
        else                     k = 4'd0;
        len_mask = 12'hFFF >> k;
        tok_len  = {1'b0, hword[11:0] & len_mask} + 13'd3;
        tok_dist = 13'(hword >> (4'd12 - k)) + 13'd1;
        tok_end  = {1'b0, pos_reg} + {1'b0, tok_len};

        if (accept && !fin_reg)
        begin
            if (op == lznt_pkg::OP_STEP)
            begin
                if (rem_reg != 13'd0)
                begin
                    req.copy = 1'b1;
                    req.wr   = 1'b1;
                    req.addr = pos_reg[11:0];
                    pos_next = pos_reg + 13'd1;
                    rem_next = rem_reg - 13'd1;
                    do_emit  = 1'b1;
                end
                else if (zf_reg)
                begin
                    do_emit = 1'b1;
                end
                else if (ended_reg)
                begin
                    do_err   = 1'b1;
                    err_code = lznt_pkg::ST_EARLY;
                end
            end
            else if (!ended_reg)
            begin
                if (rem_reg != 13'd0 || zf_reg)
                begin
                    do_err   = 1'b1;
                    err_code = lznt_pkg::ST_BUSY;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HDR_LO:
                        begin
                            held_next  = in_byte;
                            phase_next = PH_HDR_HI;
                        end
                        PH_HDR_HI:
                        begin
                            if (hword == 16'd0)
                            begin
                                zf_next = 1'b1;
                            end
                            else if (hword[14:12] != 3'd3)
                            begin
                                do_err   = 1'b1;
                                err_code = lznt_pkg::ST_SIG;
                            end
                            else
                            begin
                                left_next  = {1'b0, hword[11:0]} + 13'd1;
                                pos_next   = 13'd0;
                                slot_next  = 3'd0;
                                flags_next = 8'd0;
                                phase_next = hword[15] ? PH_FLAG : PH_STORED;
                            end
                        end
                        PH_STORED:
                        begin
                            do_emit   = 1'b1;
                            emit_data = in_byte;
                        end
                        PH_FLAG:
                        begin
                            flags_next = in_byte;
                            slot_next  = 3'd0;
                            phase_next = PH_ITEM;
                        end
                        PH_ITEM:
                        begin
                            if (!flags_reg[0])
                            begin
                                if (pos_reg >= 13'(lznt_pkg::CHUNK_BYTES))
                                begin
                                    do_err   = 1'b1;
                                    err_code = lznt_pkg::ST_OVER;
                                end
                                else
                                begin
                                    req.wr    = 1'b1;
                                    req.addr  = pos_reg[11:0];
                                    pos_next  = pos_reg + 13'd1;
                                    do_adv    = 1'b1;
                                    do_emit   = 1'b1;
                                    emit_data = in_byte;
                                end
                            end
                            else if (left_reg <= 13'd1)
                            begin
                                do_err   = 1'b1;
                                err_code = lznt_pkg::ST_EARLY;
                            end
                            else
                            begin
                                held_next  = in_byte;
                                phase_next = PH_TOKEN_HI;
                            end
                        end
                        PH_TOKEN_HI:
                        begin
                            if (pos_reg == 13'd0 || tok_dist > pos_reg)
                            begin
                                do_err   = 1'b1;
                                err_code = lznt_pkg::ST_REF;
                            end
                            else if (tok_end > 14'(lznt_pkg::CHUNK_BYTES))
                            begin
                                do_err   = 1'b1;
                                err_code = lznt_pkg::ST_OVER;
                            end
                            else
                            begin
                                rem_next   = tok_len;
                                dist_next  = tok_dist;
                                phase_next = PH_ITEM;
                                do_adv     = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HDR_LO;
                        end
                    endcase

                    // Advance to the next flag bit; refill after eight
                    if (do_adv)
                    begin
                        flags_next = {1'b0, flags_reg[7:1]};
                        slot_next  = slot_reg + 3'd1;
                        if (slot_reg == 3'd7)
                        begin
                            slot_next  = 3'd0;
                            phase_next = PH_FLAG;
                        end
                    end

                    // Count down chunk bytes for anything past the header
                    if (!do_err && phase_reg != PH_HDR_LO && phase_reg != PH_HDR_HI)
                    begin
                        if (left_reg != 13'd0)
                        begin
                            left_next = left_reg - 13'd1;
                        end
                        if (left_next == 13'd0)
                        begin
                            phase_next = PH_HDR_LO;
                        end
                    end
                end
            end
        end

        count_inc = {1'b0, produced_reg} + 22'd1;
        if (do_emit)
        begin
            req.emit      = 1'b1;
            req.data      = emit_data;
            req.status    = lznt_pkg::ST_OK;
            req.last      = count_inc >= {1'b0, output_size};
            produced_next = count_inc[20:0];
            if (req.last)
            begin
                fin_next = 1'b1;
            end
        end
        if (do_err)
        begin
            req.emit   = 1'b1;
            req.copy   = 1'b0;
            req.wr     = 1'b0;
            req.data   = 8'd0;
            req.last   = 1'b1;
            req.status = err_code;
            fin_next   = 1'b1;
        end

        if (accept && op == lznt_pkg::OP_SUPPLY && !fin_next && last_in)
        begin
            ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR_LO;
            pos_reg      <= '0;
            left_reg     <= '0;
            produced_reg <= '0;
            flags_reg    <= '0;
            slot_reg     <= '0;
            held_reg     <= '0;
            rem_reg      <= '0;
            dist_reg     <= '0;
            zf_reg       <= 1'b0;
            fin_reg      <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            produced_reg <= produced_next;
            flags_reg    <= flags_next;
            slot_reg     <= slot_next;
            held_reg     <= held_next;
            rem_reg      <= rem_next;
            dist_reg     <= dist_next;
            zf_reg       <= zf_next;
            fin_reg      <= fin_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

[design/lznt_history.sv]
//------------------------------------------------------------------------------
// lznt_history
// Chunk history memory with registered read and write-to-read forwarding.
//------------------------------------------------------------------------------
module lznt_history
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  lznt_pkg::req_t                req_in,
    input  logic [lznt_pkg::HIST_AW-1:0]  rd_addr,
    output lznt_pkg::res_t                res
);

    logic [7:0] hist_mem [lznt_pkg::CHUNK_BYTES];

    lznt_pkg::req_t req_reg;
    logic [7:0]     rdata_reg;
    logic           fwd_reg;
    logic [7:0]     fwd_data_reg;
    logic           rd_en, wr_en, fwd_next;
    logic [7:0]     value;

    assign rd_en    = adv && req_in.emit && req_in.copy;
    assign wr_en    = adv && req_reg.emit && req_reg.wr;
    // Read of the entry written this very cycle: take the written byte
    assign fwd_next = rd_en && wr_en && (rd_addr == req_reg.addr);
    assign value    = req_reg.copy ? (fwd_reg ? fwd_data_reg : rdata_reg) : req_reg.data;

    always_comb
    begin
        res.valid  = req_reg.emit;
        res.data   = value;
        res.last   = req_reg.last;
        res.status = req_reg.status;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[req_reg.addr] <= value;
        end
        if (rd_en)
        begin
            rdata_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_data_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
            fwd_reg <= 1'b0;
        end
        else if (adv)
        begin
            req_reg <= req_in;
            fwd_reg <= fwd_next;
        end
    end

endmodule

[design/lznt1_stream_decompressor.sv]
//------------------------------------------------------------------------------
// lznt1_stream_decompressor
// Streaming decompressor for one compressed unit of chunked LZ data.
//------------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per compressed byte (s_tuser = 0) or per
//   step request (s_tuser = 1). s_tlast marks the final compressed byte.
//   m_* channel: one transaction per decompressed byte or error report;
//   m_tuser carries the status, m_tlast marks the end of the unit.
//   cfg_* channel: writes the output size; write it only while idle.
// Registers: a result passes the history stage, then the output register.
// Throughput: one transaction per cycle unless stalled, even for copy steps
//   back to back at distance one; the history RAM has one write and one read
//   port, and a forwarding register covers a read of the entry being written.
// Stall: when m_tready is low with a result held, s_tready drops and the
//   whole pipe holds; a free output register lets input flow on.
// Reset: the parser returns to expecting a chunk header, counters clear,
//   output size returns to 65536. History is written before it is read,
//   so it needs no clearing.
//------------------------------------------------------------------------------
`include "lznt1_stream_decompressor_assert.svh"

module lznt1_stream_decompressor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] operation
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);

    logic                         adv;
    logic                         accept;
    logic [20:0]                  size_reg;
    lznt_pkg::req_t               req;
    lznt_pkg::res_t               res;
    logic [lznt_pkg::HIST_AW-1:0] rd_addr;
    logic                         out_valid_reg;
    logic [7:0]                   out_data_reg;
    logic                         out_last_reg;
    logic [2:0]                   out_status_reg;

    // Advance the pipe whenever the output register is free or draining
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 21'd65536;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_data;
        end
    end

    lznt_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (s_tuser),
        .in_byte     (s_tdata),
        .last_in     (s_tlast),
        .output_size (size_reg),
        .req         (req),
        .rd_addr     (rd_addr)
    );

    lznt_history u_history
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .req_in  (req),
        .rd_addr (rd_addr),
        .res     (res)
    );

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg   <= res.data;
            out_last_reg   <= res.last;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    `LZNT_ASSERT_IMP(a_err_shape, m_tvalid && (m_tuser != lznt_pkg::ST_OK),
        (m_tdata == 8'd0) && m_tlast, "error result must carry zero data and last")
    `LZNT_ASSERT_NXT(a_nothing_after_last, m_tvalid && m_tready && m_tlast,
        !m_tvalid, "result emitted after end of unit")
    `LZNT_ASSERT_IMP(a_valid_rise, $rose(m_tvalid), $past(s_tready),
        "output became valid without a pipe advance")

endmodule

[bench/lznt1_stream_decompressor_tb.sv]
//------------------------------------------------------------------------------
// lznt1_stream_decompressor_tb
// Self-checking bench: drives well-formed stored and compressed chunks with
// random content through the stream input. A built-in predictor tracks the
// parser, the per-chunk history and the output count, and every output
// transaction is compared in order. The unit is closed by one randomly
// chosen ending (size reached, or one of the error reports).
//------------------------------------------------------------------------------
module lznt1_stream_decompressor_tb;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } lz_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } lz_result_t;

    typedef enum logic [2:0] {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_STORED,
        PH_FLAG,
        PH_ITEM,
        PH_TOKEN_HI
    } lz_phase_t;

    typedef enum int {
        END_SIZE,
        END_SIG,
        END_BUSY,
        END_EARLY,
        END_REF,
        END_OVER,
        END_CUT
    } lz_ending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;   // [0] operation
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic [2:0]  m_tuser;          // [2:0] status
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [20:0] cfg_data = 21'd0;

    // Expected decompressed bytes and error reports, oldest first
    lz_result_t  pending_results[$];
    // Input transactions waiting to be sent
    lz_item_t    plan[$];

    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    bit          quiet = 1'b0;     // no idling on either side
    bit          burst_send = 1'b0; // sender offers back to back
    bit          hold_long = 1'b0;  // receiver stalls for a long stretch

    // Decompressor shadow state
    logic [7:0]  hist [0:4095];
    int unsigned out_size = 65536;
    int unsigned chunk_pos;
    int unsigned chunk_left;
    int unsigned produced;
    lz_phase_t   phase;
    logic [7:0]  flags;
    int unsigned slot;
    logic [7:0]  held;
    int unsigned copy_left;
    int unsigned copy_dist;
    bit          zero_fill;
    bit          unit_done;
    bit          input_done;

    lznt1_stream_decompressor uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    //--------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------
    function void post_result(logic [7:0] d, logic l, logic [2:0] s);
        pending_results.push_back('{d, l, s});
    endfunction

    // An error report closes the unit
    function void report_error(logic [2:0] code);
        post_result(8'd0, 1'b1, code);
        unit_done = 1'b1;
    endfunction

    // Emit one byte; the byte that reaches the output size closes the unit
    function void emit_byte(logic [7:0] v);
        bit at_end;
        at_end   = (produced + 1) >= out_size;
        produced = (produced + 1) & 32'h1F_FFFF;
        if (at_end)
            unit_done = 1'b1;
        post_result(v, at_end, lznt_pkg::ST_OK);
    endfunction

    function void next_slot();
        flags = flags >> 1;
        slot++;
        if (slot >= 8)
        begin
            slot  = 0;
            phase = PH_FLAG;
        end
    endfunction

    function void take_chunk_byte(logic [7:0] b);
        logic [15:0] word;
        int unsigned u;
        int unsigned mask;
        int unsigned sh;
        int unsigned len;
        int unsigned distance;
        case (phase)
            PH_STORED:
                emit_byte(b);
            PH_FLAG:
            begin
                flags = b;
                slot  = 0;
                phase = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (!flags[0])
                begin
                    if (chunk_pos >= lznt_pkg::CHUNK_BYTES)
                    begin
                        report_error(lznt_pkg::ST_OVER);
                        return;
                    end
                    hist[chunk_pos & 12'hFFF] = b;
                    chunk_pos++;
                    next_slot();
                    emit_byte(b);
                end
                else
                begin
                    // Token whose first byte ends the chunk
                    if (chunk_left <= 1)
                    begin
                        report_error(lznt_pkg::ST_EARLY);
                        return;
                    end
                    held  = b;
                    phase = PH_TOKEN_HI;
                end
            end
            default:
            begin
                word = {b, held};
                if (chunk_pos == 0)
                begin
                    report_error(lznt_pkg::ST_REF);
                    return;
                end
                // Offset field widens as the chunk position grows
                u    = chunk_pos - 1;
                mask = 12'hFFF;
                sh   = 12;
                while (u >= 16 && sh > 0)
                begin
                    mask >>= 1;
                    sh--;
                    u >>= 1;
                end
                len      = (word & mask) + 3;
                distance = (word >> sh) + 1;
                if (distance > chunk_pos)
                begin
                    report_error(lznt_pkg::ST_REF);
                    return;
                end
                if (chunk_pos + len > lznt_pkg::CHUNK_BYTES)
                begin
                    report_error(lznt_pkg::ST_OVER);
                    return;
                end
                copy_left = len;
                copy_dist = distance;
                phase     = PH_ITEM;
                next_slot();
            end
        endcase
        if (chunk_left > 0)
            chunk_left--;
        if (chunk_left == 0)
            phase = PH_HDR_LO;
    endfunction

    function void predict_item(lz_item_t it);
        logic [15:0] h;
        logic [7:0]  v;
        if (unit_done)
            return;
        if (it.op == lznt_pkg::OP_STEP)
        begin
            if (copy_left > 0)
            begin
                v = hist[(chunk_pos - copy_dist) & 12'hFFF];
                hist[chunk_pos & 12'hFFF] = v;
                chunk_pos++;
                copy_left--;
                emit_byte(v);
            end
            else if (zero_fill)
                emit_byte(8'd0);
            else if (input_done)
                report_error(lznt_pkg::ST_EARLY);
            return;
        end
        if (input_done)
            return;
        if (copy_left > 0 || zero_fill)
        begin
            report_error(lznt_pkg::ST_BUSY);
            return;
        end
        case (phase)
            PH_HDR_LO:
            begin
                held  = it.data;
                phase = PH_HDR_HI;
            end
            PH_HDR_HI:
            begin
                h = {it.data, held};
                if (h == 16'd0)
                    zero_fill = 1'b1;
                else if (h[14:12] != 3'd3)
                begin
                    report_error(lznt_pkg::ST_SIG);
                    return;
                end
                else
                begin
                    chunk_left = h[11:0] + 1;
                    chunk_pos  = 0;
                    slot       = 0;
                    flags      = 8'd0;
                    phase      = h[15] ? PH_FLAG : PH_STORED;
                end
            end
            default:
            begin
                take_chunk_byte(it.data);
                if (unit_done)
                    return;
            end
        endcase
        if (it.last)
            input_done = 1'b1;
    endfunction

    //--------------------------------------------------------------------------
    // Sender: call at a rising edge; returns at the edge of acceptance
    //--------------------------------------------------------------------------
    task automatic send_item(lz_item_t it);
        if (!quiet && !burst_send && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= it.data;
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_plan();
        while (plan.size() > 0)
            send_item(plan.pop_front());
    endtask

    task automatic push_supply(logic [7:0] b, logic l = 1'b0);
        plan.push_back('{lznt_pkg::OP_SUPPLY, b, l});
    endtask

    task automatic push_steps(int n);
        repeat (n) plan.push_back('{lznt_pkg::OP_STEP, 8'($urandom), 1'b0});
    endtask

    // Hold the sender until every expected result has come, then let the
    // pipe settle; s_tvalid drops for the pause
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_out_size(logic [20:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        out_size = v;
        cfg_writes++;
    endtask

    task automatic push_raw_chunk(int n);
        logic [15:0] h;
        h = 16'h3000 | 16'(n - 1);
        push_supply(h[7:0]);
        push_supply(h[15:8]);
        repeat (n) push_supply(8'($urandom));
    endtask

    // Compressed chunk of n_items literals and copy tokens, each token
    // followed by the steps that drain its copy
    task automatic push_lz_chunk(int n_items, int max_len);
        lz_item_t    body[$];
        logic [15:0] word[8];
        int          len_of[8];
        logic [7:0]  flag;
        logic [15:0] h;
        int          p;
        int          g;
        int          nbytes;
        int          u;
        int          sh;
        int          lim;
        int          distance;
        int          mask;
        p      = 0;
        nbytes = 0;
        while (n_items > 0)
        begin
            g        = (n_items > 8) ? 8 : n_items;
            n_items -= g;
            flag     = 8'd0;
            for (int i = 0; i < g; i++)
            begin
                if (p > 0 && p < 4000 && $urandom_range(0, 2) == 0)
                begin
                    u    = p - 1;
                    sh   = 12;
                    mask = 12'hFFF;
                    while (u >= 16 && sh > 0)
                    begin
                        u >>= 1;
                        sh--;
                        mask >>= 1;
                    end
                    lim = mask + 3;
                    if (lim > max_len)
                        lim = max_len;
                    if (lim > 4096 - p)
                        lim = 4096 - p;
                    len_of[i] = $urandom_range(3, lim);
                    case ($urandom_range(0, 3))
                        0:       distance = 1;
                        1:       distance = p;
                        default: distance = $urandom_range(1, p);
                    endcase
                    word[i] = 16'(((distance - 1) << sh) | (len_of[i] - 3));
                    flag[i] = 1'b1;
                    p      += len_of[i];
                    nbytes += 2;
                end
                else
                begin
                    word[i] = 16'($urandom_range(0, 255));
                    p++;
                    nbytes++;
                end
            end
            nbytes++;
            body.push_back('{lznt_pkg::OP_SUPPLY, flag, 1'b0});
            for (int i = 0; i < g; i++)
            begin
                body.push_back('{lznt_pkg::OP_SUPPLY, word[i][7:0], 1'b0});
                if (flag[i])
                begin
                    body.push_back('{lznt_pkg::OP_SUPPLY, word[i][15:8], 1'b0});
                    repeat (len_of[i])
                        body.push_back('{lznt_pkg::OP_STEP, 8'($urandom), 1'b0});
                end
            end
        end
        h = 16'hB000 | 16'(nbytes - 1);
        push_supply(h[7:0]);
        push_supply(h[15:8]);
        foreach (body[i])
            plan.push_back(body[i]);
    endtask

    //--------------------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off on request
    //--------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(posedge clk);
            end
        end
    end

    //--------------------------------------------------------------------------
    // Checker: compare each output transaction with the oldest expectation
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lz_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result data=%h last=%b status=%0d",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last
                    || m_tuser !== want.status)
                begin
                    $display("%0t: mismatch expected data=%h last=%b status=%0d",
                             $time, want.data, want.last, want.status,
                             " actual data=%h last=%b status=%0d",
                             m_tdata, m_tlast, m_tuser);
                    errors++;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // Both extremes of the output size, written right after reset
    task automatic test_size_extremes();
        write_out_size(21'd1);
        write_out_size(21'd1048576);
    endtask

    // Idle steps, then a stored chunk with the byte extremes
    task automatic test_stored_extremes();
        push_steps(2);
        push_supply(8'h05);
        push_supply(8'h30);
        push_supply(8'h00);
        push_supply(8'hFF);
        push_supply(8'h55);
        push_supply(8'hAA);
        push_supply(8'h80);
        push_supply(8'h01);
        send_plan();
    endtask

    // Literal, distance-one copy, copy from the chunk start, literal
    task automatic test_copy_tokens();
        push_supply(8'h06);
        push_supply(8'hB0);
        push_supply(8'b0000_0110);
        push_supply(8'hFF);
        push_supply(8'h00);
        push_supply(8'h00);
        push_steps(3);
        push_supply(8'h02);
        push_supply(8'h30);
        push_steps(5);
        push_supply(8'h00);
        send_plan();
    endtask

    // Stall the output long enough to back up the input
    task automatic test_backpressure();
        drain();
        hold_long  = 1'b1;
        burst_send = 1'b1;
        push_raw_chunk(40);
        send_plan();
        burst_send = 1'b0;
        drain();
    endtask

    task automatic test_random_chunks();
        while (items_sent < 790)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    push_raw_chunk($urandom_range(1, 24));
                9:
                    push_steps($urandom_range(1, 3));
                default:
                    push_lz_chunk($urandom_range(1, 30),
                                  ($urandom_range(0, 7) == 0) ? 66 : 18);
            endcase
            send_plan();
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                write_out_size(21'($urandom_range(produced + 5000, 1048576)));
            end
        end
    endtask

    // Close the unit one way, then offer items that must be ignored
    task automatic test_ending(lz_ending_t how);
        quiet = 1'b1;
        drain();
        case (how)
            END_SIZE:
            begin
                write_out_size(21'(produced + 4));
                push_supply(8'h00);
                push_supply(8'h00);
                push_steps(8);
            end
            END_SIG:
            begin
                push_supply(8'h00);
                push_supply(8'h10);
            end
            END_BUSY:
            begin
                push_supply(8'h04);
                push_supply(8'hB0);
                push_supply(8'h02);
                push_supply(8'h11);
                push_supply(8'h00);
                push_supply(8'h00);
                push_supply(8'h22);
            end
            END_EARLY:
            begin
                push_supply(8'h09);
                push_supply(8'h30);
                push_supply(8'h41);
                push_supply(8'h42);
                push_supply(8'h43, 1'b1);
                push_supply(8'h44);
                push_steps(1);
            end
            END_REF:
            begin
                push_supply(8'h02);
                push_supply(8'hB0);
                push_supply(8'h01);
                push_supply(8'h05);
                push_supply(8'h00);
            end
            END_OVER:
            begin
                push_supply(8'h04);
                push_supply(8'hB0);
                push_supply(8'h02);
                push_supply(8'h7E);
                push_supply(8'hFD);
                push_supply(8'h0F);
            end
            default:
            begin
                push_supply(8'h01);
                push_supply(8'hB0);
                push_supply(8'h01);
                push_supply(8'h33);
            end
        endcase
        repeat (6)
            plan.push_back('{1'($urandom), 8'($urandom), 1'($urandom)});
        send_plan();
    endtask

    initial
    begin
        lz_ending_t how;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_size_extremes();
        test_stored_extremes();
        test_copy_tokens();
        test_backpressure();
        test_random_chunks();
        how = lz_ending_t'($urandom_range(0, 6));
        test_ending(how);
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d input items, %0d results, %0d size writes, ending %s",
                 items_sent, results_seen, cfg_writes, how.name());
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3_200_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
